// ===== rtl/core/skht_pkg.sv =====
// ----------------------------------------------------------------------------
// skht_pkg: shared types and constants of the string keyed handle table
// Holds the table geometry, the transaction structs and the control and
// token structs that pass between the top level and the slot cells.
// ----------------------------------------------------------------------------
package skht_pkg;

	// Table geometry
	localparam int ENTRIES = 32;
	localparam int KEY_LEN = 64;
	localparam int IW      = $clog2(ENTRIES);
	localparam int AW      = $clog2(KEY_LEN);
	localparam int PW      = $clog2(KEY_LEN + 1);

	// Request types
	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_RESOLVE  = 1'b1;

	// Status codes
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	// Key terminator
	localparam logic [7:0] KEY_END = 8'h00;

	// Input transaction
	typedef struct packed {
		logic        req_type;
		logic [7:0]  key_char;
		logic [31:0] handle;
	} in_t;

	// Result transaction
	typedef struct packed {
		logic        status;
		logic [31:0] found_handle;
	} out_t;

	// Broadcast control from the top level to every cell
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [7:0]    wdata;
		logic [AW-1:0] raddr;
		logic          cmp;
		logic [7:0]    cmp_ch;
		logic          cmp_ok;
		logic          term;
		logic          term_ok;
		logic          req_type;
		logic [31:0]   hdl;
		logic          claim;
		logic [IW-1:0] claim_idx;
	} ctl_t;

	// Token swept along the chain on a terminator
	typedef struct packed {
		logic          valid;
		logic          hit;
		logic          free_seen;
		logic [IW-1:0] free_idx;
		logic [31:0]   found;
	} tok_t;

endpackage

// ===== rtl/core/skht_cell.sv =====
// ----------------------------------------------------------------------------
// skht_cell: one slot of the handle table
// Keeps the slot's key characters, handle, used mark and match flag, compares
// each arriving character and passes the lookup token on to its neighbour.
// ----------------------------------------------------------------------------
module skht_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [skht_pkg::IW-1:0] idx,
	input  skht_pkg::ctl_t          ctl,
	input  skht_pkg::tok_t          tok_i,
	output skht_pkg::tok_t          tok_o
);

	logic [7:0]  key_mem [skht_pkg::KEY_LEN];
	logic [7:0]  rdata_q;
	logic [31:0] handle_q;
	logic        used_q;
	logic        match_q;
	logic        endm_q;
	skht_pkg::tok_t tok_q;
	logic        claim_here;
	logic        hit_here;
	logic        free_here;

	assign claim_here = ctl.claim && (ctl.claim_idx == idx);
	assign hit_here   = tok_i.valid && !tok_i.hit && endm_q;
	assign free_here  = tok_i.valid && !used_q && !tok_i.free_seen;

	// Key memory: characters are staged into free slots, the claim writes the end mark.
	always_ff @(posedge clk) begin
		if ((ctl.we && !used_q) || claim_here) begin
			key_mem[ctl.waddr] <= ctl.wdata;
		end
		rdata_q <= key_mem[ctl.raddr];
	end

	// Handle store is updated on a matching register with a non-zero handle or on a claim.
	always_ff @(posedge clk) begin
		if (claim_here || (hit_here && ctl.req_type == skht_pkg::REQ_REGISTER &&
				ctl.hdl != 32'd0)) begin
			handle_q <= ctl.hdl;
		end
	end

	// Used mark, match flag and end-of-key match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			match_q <= 1'b1;
			endm_q  <= 1'b0;
		end else begin
			if (claim_here) begin
				used_q <= 1'b1;
			end
			if (ctl.term) begin
				match_q <= 1'b1;
				endm_q  <= used_q && match_q && ctl.term_ok && (rdata_q == skht_pkg::KEY_END);
			end else if (ctl.cmp) begin
				match_q <= match_q && ctl.cmp_ok && (rdata_q == ctl.cmp_ch);
			end
		end
	end

	// Token stage: the first hit and the lowest free slot are recorded on the way.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid     <= tok_i.valid;
			tok_q.hit       <= tok_i.hit || hit_here;
			tok_q.free_seen <= tok_i.free_seen || free_here;
			tok_q.free_idx  <= free_here ? idx : tok_i.free_idx;
			tok_q.found     <= (hit_here && ctl.req_type == skht_pkg::REQ_RESOLVE) ?
				handle_q : tok_i.found;
		end
	end

	assign tok_o = tok_q;

endmodule

// ===== rtl/core/string_keyed_handle_table_top.sv =====
// ----------------------------------------------------------------------------
// string_keyed_handle_table_top: string keyed handle table
// A terminator is compared in every cell, then a lookup token sweeps along the cells;
// the result and its done strobe are registered as the token leaves the last cell.
// Throughput: one character per cycle while busy is low; busy stays high from the
// terminator until the result, so the next key waits for the result.
// Reset clears all used marks at once; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module string_keyed_handle_table_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  skht_pkg::in_t   cmd,
	output logic            done,
	output skht_pkg::out_t  rsp
);

	logic                    accept;
	logic                    is_end;
	logic [skht_pkg::PW-1:0] pos_q;
	logic                    busy_q;
	logic                    v_s1;
	logic                    end_s1;
	logic [7:0]              ch_s1;
	logic                    cmp_ok_s1;
	logic                    term_ok_s1;
	logic [skht_pkg::AW-1:0] term_pos_q;
	logic                    req_q;
	logic [31:0]             hdl_q;
	logic                    inj_q;
	logic                    done_q;
	skht_pkg::out_t          rsp_q;
	logic                    stage_we;
	logic                    claim;
	logic                    fin;
	skht_pkg::ctl_t          ctl;
	skht_pkg::tok_t          tok_head;
	skht_pkg::tok_t          tok [skht_pkg::ENTRIES+1];
	skht_pkg::tok_t          last;
	logic [skht_pkg::ENTRIES-1:0] tok_valid;

	assign accept   = start && !busy_q;
	assign is_end   = (cmd.key_char == skht_pkg::KEY_END);
	assign stage_we = accept && !is_end &&
		(pos_q < skht_pkg::PW'(skht_pkg::KEY_LEN - 1));
	assign last     = tok[skht_pkg::ENTRIES];
	assign fin      = last.valid;
	assign claim    = fin && (req_q == skht_pkg::REQ_REGISTER) && (hdl_q != 32'd0) &&
		!last.hit && last.free_seen;

	// Character position and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			busy_q <= 1'b0;
			v_s1   <= 1'b0;
			inj_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			inj_q  <= v_s1 && end_s1;
			done_q <= fin;
			if (accept) begin
				if (is_end) begin
					pos_q  <= '0;
					busy_q <= 1'b1;
				end else if (pos_q < skht_pkg::PW'(skht_pkg::KEY_LEN - 1)) begin
					pos_q <= pos_q + 1'b1;
				end else begin
					pos_q <= skht_pkg::PW'(skht_pkg::KEY_LEN);
				end
			end else if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Compare stage operands and the request held for the sweep.
	always_ff @(posedge clk) begin
		if (accept) begin
			end_s1     <= is_end;
			ch_s1      <= cmd.key_char;
			cmp_ok_s1  <= (pos_q < skht_pkg::PW'(skht_pkg::KEY_LEN - 1));
			term_ok_s1 <= (pos_q < skht_pkg::PW'(skht_pkg::KEY_LEN));
		end
		if (accept && is_end) begin
			req_q      <= cmd.req_type;
			hdl_q      <= cmd.handle;
			term_pos_q <= (pos_q < skht_pkg::PW'(skht_pkg::KEY_LEN - 1)) ?
				pos_q[skht_pkg::AW-1:0] : skht_pkg::AW'(skht_pkg::KEY_LEN - 1);
		end
	end

	// Result of the transaction once the token leaves the last cell.
	always_ff @(posedge clk) begin
		if (fin) begin
			if (req_q == skht_pkg::REQ_RESOLVE) begin
				rsp_q.status       <= last.hit ? skht_pkg::ST_OK : skht_pkg::ST_FAIL;
				rsp_q.found_handle <= last.hit ? last.found : 32'd0;
			end else begin
				rsp_q.status       <= ((hdl_q != 32'd0) && (last.hit || last.free_seen)) ?
					skht_pkg::ST_OK : skht_pkg::ST_FAIL;
				rsp_q.found_handle <= 32'd0;
			end
		end
	end

	// Broadcast control to the cells.
	always_comb begin
		ctl.we        = stage_we;
		ctl.waddr     = claim ? term_pos_q : pos_q[skht_pkg::AW-1:0];
		ctl.wdata     = claim ? skht_pkg::KEY_END : cmd.key_char;
		ctl.raddr     = pos_q[skht_pkg::AW-1:0];
		ctl.cmp       = v_s1 && !end_s1;
		ctl.cmp_ch    = ch_s1;
		ctl.cmp_ok    = cmp_ok_s1;
		ctl.term      = v_s1 && end_s1;
		ctl.term_ok   = term_ok_s1;
		ctl.req_type  = req_q;
		ctl.hdl       = hdl_q;
		ctl.claim     = claim;
		ctl.claim_idx = last.free_idx;
	end

	// Token entering the first cell.
	always_comb begin
		tok_head       = '0;
		tok_head.valid = inj_q;
	end

	assign tok[0] = tok_head;

	// Row of slot cells.
	for (genvar i = 0; i < skht_pkg::ENTRIES; i++) begin : g_cell
		skht_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (skht_pkg::IW'(i)),
			.ctl    (ctl),
			.tok_i  (tok[i]),
			.tok_o  (tok[i+1])
		);
		assign tok_valid[i] = tok[i+1].valid;
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// Only one lookup token travels the chain at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_valid, inj_q}))
		else $error("more than one lookup token in the chain");

	// A result only follows a sweep that ran while busy.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("result without a pending terminator");

	// An accepted terminator makes the block busy.
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_end) |=> busy_q)
		else $error("terminator accepted without going busy");

	// A claim only happens for a register request with a non-zero handle.
	a_claim_ok: assert property (@(posedge clk) disable iff (!arst_n)
		claim |-> (busy_q && hdl_q != 32'd0 && req_q == skht_pkg::REQ_REGISTER))
		else $error("slot claimed without a valid register request");

endmodule
